/* sv/ray_obb_nearest_hit_top_defines.svh */
// ----------------------------------------------------------------------------
// Ray/OBB nearest hit: assertion macros
// Concurrent assertion helpers; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef RAY_OBB_NEAREST_HIT_TOP_DEFINES_SVH
`define RAY_OBB_NEAREST_HIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ROB_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rob assertion failed");
`define ROB_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rob assertion failed");
`else
`define ROB_ASSERT_IMP(lbl, clk, rst, pre, post)
`define ROB_ASSERT_NXT(lbl, clk, rst, pre, post)
`endif
`endif

/* sv/rob_pkg.sv */
// ----------------------------------------------------------------------------
// Ray/OBB nearest hit: package
// Sizes, operation codes and transaction types shared by all modules.
// ----------------------------------------------------------------------------
`default_nettype none
package rob_pkg;
   localparam int BOX_SLOTS     = 64;
   localparam int WORDS_PER_BOX = 15;
   localparam int CTR_WORDS     = 3;
   localparam int EXT_BASE      = 12;
   localparam int AXIS_WORDS    = WORDS_PER_BOX - CTR_WORDS;
   localparam int MEM_DEPTH     = BOX_SLOTS * WORDS_PER_BOX;
   localparam int ADDR_W        = $clog2(MEM_DEPTH);
   localparam int BASE_W        = $clog2(MEM_DEPTH + 1);
   localparam int SCAN_W        = $clog2(BOX_SLOTS + 1);
   localparam int SLOT_IDX_W    = (BOX_SLOTS > 1) ? $clog2(BOX_SLOTS) : 1;
   localparam int SLOT_W        = 6;
   localparam int WIDX_W        = 4;
   localparam int THR_W         = 16;
   localparam int DIST_W        = 31;
   localparam int FRAC          = 16;
   localparam int DIFF_W        = 33;
   localparam int PROD_W        = 65;
   localparam int O_W           = 51;
   localparam int D_W           = 50;
   localparam int NUM_W         = 52;
   localparam int PSUM_W        = 50;
   localparam int T_W           = 42;
   localparam int Q_W           = 41;
   localparam int SAT_SHIFT     = 40;
   localparam int REM_W         = NUM_W + FRAC;
   localparam int DSH_W         = D_W + Q_W;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
   localparam logic signed [T_W-1:0] T_SAT = T_W'(64'd1 << SAT_SHIFT);

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_ENABLE = 2'd1;
   localparam logic [1:0] OP_CAST   = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [SLOT_W-1:0]  slot;
      logic [WIDX_W-1:0]  word_index;
      logic signed [31:0] word_value;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic [DIST_W-1:0]  max_distance;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  hit_slot;
      logic [DIST_W-1:0]  hit_distance;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic signed [NUM_W-1:0] num;
      logic signed [D_W-1:0]   den;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic signed [T_W-1:0] quo;
   } div_rsp_type;
endpackage
`default_nettype wire

/* sv/rob_div.sv */
// ----------------------------------------------------------------------------
// Ray/OBB nearest hit: slab divider
// Serial restoring divider, signed Q25.16 quotient truncated toward zero and
// saturated to +-2^40; one saturation check then one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rob_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rob_pkg::div_req_type req,
   output rob_pkg::div_rsp_type rsp
);
   logic busy_ff, busy_in, done_ff, done_in, first_ff, first_in, neg_ff, neg_in;
   logic [5:0] k_ff, k_in;
   logic [rob_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [rob_pkg::DSH_W-1:0] dsh_ff, dsh_in;
   logic [rob_pkg::Q_W-1:0] q_ff, q_in;
   logic signed [rob_pkg::T_W-1:0] res_ff, res_in, mag;
   logic [rob_pkg::NUM_W-1:0] num_mag;
   logic [rob_pkg::D_W-1:0] den_mag;
   logic ge, fin;

   assign num_mag = req.num < 0 ? rob_pkg::NUM_W'(-req.num) : rob_pkg::NUM_W'(req.num);
   assign den_mag = req.den < 0 ? rob_pkg::D_W'(-req.den) : rob_pkg::D_W'(req.den);
   assign ge = rob_pkg::DSH_W'(rem_ff) >= dsh_ff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      first_in = first_ff;
      neg_in   = neg_ff;
      k_in     = k_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      mag      = '0;
      fin      = 1'b0;
      if (!busy_ff) begin
         if (req.start) begin
            busy_in  = 1'b1;
            first_in = 1'b1;
            neg_in   = (req.num < 0) != (req.den < 0);
            k_in     = 6'(rob_pkg::Q_W - 1);
            rem_in   = rob_pkg::REM_W'(num_mag) << rob_pkg::FRAC;
            dsh_in   = rob_pkg::DSH_W'(den_mag) << rob_pkg::Q_W;
            q_in     = '0;
         end
      end else if (first_ff) begin
         if (ge) begin
            fin = 1'b1;
            mag = rob_pkg::T_SAT;
         end else begin
            first_in = 1'b0;
            dsh_in   = dsh_ff >> 1;
         end
      end else begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff[rob_pkg::REM_W-1:0];
         end
         q_in   = {q_ff[rob_pkg::Q_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         k_in   = k_ff - 6'd1;
         if (k_ff == 6'd0) begin
            fin = 1'b1;
            mag = rob_pkg::T_W'(q_in);
            if (mag > rob_pkg::T_SAT) begin
               mag = rob_pkg::T_SAT;
            end
         end
      end
      if (fin) begin
         busy_in = 1'b0;
         done_in = 1'b1;
         res_in  = neg_ff ? -mag : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      first_ff <= first_in;
      neg_ff   <= neg_in;
      k_ff     <= k_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
      res_ff   <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = res_ff;
endmodule
`default_nettype wire

/* sv/rob_core.sv */
// ----------------------------------------------------------------------------
// Ray/OBB nearest hit: core
// Box word memory, slot enables and the per-slot slab test sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module rob_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  rob_pkg::req_type              in_data,
   input  logic [rob_pkg::THR_W-1:0]     thr,
   output logic                          res_valid,
   input  logic                          res_ready,
   output rob_pkg::rsp_type              res_data
);
   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,
      ST_SCAN = 12'b000000000010,
      ST_LOAD = 12'b000000000100,
      ST_MUL  = 12'b000000001000,
      ST_ACC  = 12'b000000010000,
      ST_AXIS = 12'b000000100000,
      ST_DIV1 = 12'b000001000000,
      ST_DIV2 = 12'b000010000000,
      ST_FIN  = 12'b000100000000,
      ST_PMUL = 12'b001000000000,
      ST_PACC = 12'b010000000000,
      ST_DONE = 12'b100000000000
   } state_type;

   localparam logic signed [rob_pkg::PSUM_W-1:0] P_MAX = rob_pkg::PSUM_W'(2147483647);
   localparam logic signed [rob_pkg::PSUM_W-1:0] P_MIN = -P_MAX - 1;

   state_type state_ff, state_in;
   logic signed [31:0] box_mem [rob_pkg::MEM_DEPTH];
   logic signed [31:0] rd_data_ff;
   logic [rob_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic mem_we, accept;

   logic [rob_pkg::BOX_SLOTS-1:0] en_ff, en_in;
   logic signed [31:0] org_ff [3];
   logic signed [31:0] org_in [3];
   logic signed [31:0] dir_ff [3];
   logic signed [31:0] dir_in [3];
   logic [rob_pkg::DIST_W-1:0] best_ff, best_in;
   logic found_ff, found_in;
   logic [rob_pkg::SLOT_W-1:0] bslot_ff, bslot_in;
   logic [rob_pkg::SCAN_W-1:0] scan_ff, scan_in;
   logic [rob_pkg::BASE_W-1:0] base_ff, base_in;
   logic [3:0] ld_cnt_ff, ld_cnt_in, rd_idx_ff, rd_idx_in;
   logic rd_vld_ff, rd_vld_in;
   logic signed [rob_pkg::DIFF_W-1:0] diff_ff [3];
   logic signed [rob_pkg::DIFF_W-1:0] diff_in [3];
   logic signed [31:0] w_ff [rob_pkg::AXIS_WORDS];
   logic signed [31:0] w_in [rob_pkg::AXIS_WORDS];
   logic [1:0] ax_ff, ax_in, mi_ff, mi_in;
   logic ph_ff, ph_in;
   logic signed [rob_pkg::PROD_W-1:0] prod_ff, prod_c;
   logic signed [rob_pkg::O_W-1:0] o_ff, o_in;
   logic signed [rob_pkg::D_W-1:0] d_ff, d_in;
   logic signed [rob_pkg::T_W-1:0] tmin_ff, tmin_in, tmax_ff, tmax_in, t1_ff, t1_in;
   logic signed [rob_pkg::T_W-1:0] lo, hi, tmin_n, tmax_n;
   logic signed [31:0] pt_ff [3];
   logic signed [31:0] pt_in [3];

   logic signed [rob_pkg::DIFF_W-1:0] mul_a;
   logic signed [31:0] mul_b, w_sel, org_sel;
   logic [3:0] w_idx;
   logic [1:0] org_idx;
   logic signed [rob_pkg::NUM_W-1:0] e_n, o_n;
   logic [rob_pkg::D_W-1:0] absd;
   logic par, axis_end, next_slot;
   logic signed [rob_pkg::PSUM_W-1:0] psum;
   rob_pkg::div_req_type div_req;
   rob_pkg::div_rsp_type div_rsp;

   rob_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign in_ready = state_ff == ST_IDLE;
   assign accept   = in_valid && in_ready;
   assign mem_we   = accept && in_data.operation == rob_pkg::OP_WRITE
                     && int'(in_data.word_index) < rob_pkg::WORDS_PER_BOX
                     && int'(in_data.slot) < rob_pkg::BOX_SLOTS;
   assign wr_addr  = rob_pkg::ADDR_W'(int'(in_data.slot) * rob_pkg::WORDS_PER_BOX
                     + int'(in_data.word_index));
   assign rd_addr  = rob_pkg::ADDR_W'(base_ff + rob_pkg::BASE_W'(ld_cnt_ff));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         box_mem[wr_addr] <= in_data.word_value;
      end
      rd_data_ff <= box_mem[rd_addr];
   end

   assign w_idx   = (state_ff == ST_MUL) ? 4'(3 * int'(ax_ff) + int'(mi_ff))
                                         : 4'(rob_pkg::EXT_BASE - rob_pkg::CTR_WORDS
                                              + int'(ax_ff));
   assign w_sel   = w_ff[w_idx];
   assign org_idx = (state_ff == ST_LOAD) ? rd_idx_ff[1:0] : mi_ff;
   assign org_sel = org_ff[org_idx];
   assign mul_a   = (state_ff == ST_PMUL) ? $signed({2'b00, best_ff})
                  : ph_ff ? $signed({dir_ff[mi_ff][31], dir_ff[mi_ff]}) : diff_ff[mi_ff];
   assign mul_b   = (state_ff == ST_PMUL) ? dir_ff[mi_ff] : w_sel;
   assign prod_c  = mul_a * mul_b;

   assign e_n  = rob_pkg::NUM_W'(w_sel);
   assign o_n  = rob_pkg::NUM_W'(o_ff);
   assign absd = d_ff < 0 ? rob_pkg::D_W'(-d_ff) : rob_pkg::D_W'(d_ff);
   assign par  = d_ff == '0 || absd < rob_pkg::D_W'(thr);
   assign lo   = (t1_ff > div_rsp.quo) ? div_rsp.quo : t1_ff;
   assign hi   = (t1_ff > div_rsp.quo) ? t1_ff : div_rsp.quo;
   assign tmin_n = (lo > tmin_ff) ? lo : tmin_ff;
   assign tmax_n = (hi < tmax_ff) ? hi : tmax_ff;
   assign psum = rob_pkg::PSUM_W'(org_sel)
               + rob_pkg::PSUM_W'($signed(prod_ff[rob_pkg::PROD_W-1:rob_pkg::FRAC]));

   always_comb begin
      state_in  = state_ff;
      en_in     = en_ff;
      org_in    = org_ff;
      dir_in    = dir_ff;
      best_in   = best_ff;
      found_in  = found_ff;
      bslot_in  = bslot_ff;
      scan_in   = scan_ff;
      base_in   = base_ff;
      ld_cnt_in = ld_cnt_ff;
      rd_idx_in = rd_idx_ff;
      rd_vld_in = 1'b0;
      diff_in   = diff_ff;
      w_in      = w_ff;
      ax_in     = ax_ff;
      mi_in     = mi_ff;
      ph_in     = ph_ff;
      o_in      = o_ff;
      d_in      = d_ff;
      tmin_in   = tmin_ff;
      tmax_in   = tmax_ff;
      t1_in     = t1_ff;
      pt_in     = pt_ff;
      axis_end  = 1'b0;
      next_slot = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = -e_n - o_n;
      div_req.den   = d_ff;
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (in_data.operation)
                  rob_pkg::OP_ENABLE: begin
                     if (int'(in_data.slot) < rob_pkg::BOX_SLOTS) begin
                        en_in[rob_pkg::SLOT_IDX_W'(in_data.slot)] = in_data.word_value[0];
                     end
                  end
                  rob_pkg::OP_CAST: begin
                     org_in[0] = in_data.origin_x;
                     org_in[1] = in_data.origin_y;
                     org_in[2] = in_data.origin_z;
                     dir_in[0] = in_data.dir_x;
                     dir_in[1] = in_data.dir_y;
                     dir_in[2] = in_data.dir_z;
                     best_in   = in_data.max_distance;
                     found_in  = 1'b0;
                     bslot_in  = '0;
                     scan_in   = '0;
                     base_in   = '0;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_ff == rob_pkg::SCAN_W'(rob_pkg::BOX_SLOTS)) begin
               mi_in    = '0;
               state_in = found_ff ? ST_PMUL : ST_DONE;
            end else if (en_ff[scan_ff[rob_pkg::SLOT_IDX_W-1:0]]) begin
               tmin_in   = '0;
               tmax_in   = rob_pkg::T_SAT;
               ld_cnt_in = '0;
               ax_in     = '0;
               state_in  = ST_LOAD;
            end else begin
               next_slot = 1'b1;
            end
         end
         ST_LOAD: begin
            if (int'(ld_cnt_ff) < rob_pkg::WORDS_PER_BOX) begin
               rd_vld_in = 1'b1;
               rd_idx_in = ld_cnt_ff;
               ld_cnt_in = ld_cnt_ff + 4'd1;
            end
            if (rd_vld_ff) begin
               if (int'(rd_idx_ff) < rob_pkg::CTR_WORDS) begin
                  diff_in[rd_idx_ff[1:0]] = $signed({org_sel[31], org_sel})
                                          - $signed({rd_data_ff[31], rd_data_ff});
               end else begin
                  w_in[4'(int'(rd_idx_ff) - rob_pkg::CTR_WORDS)] = rd_data_ff;
               end
               if (int'(rd_idx_ff) == rob_pkg::WORDS_PER_BOX - 1) begin
                  mi_in    = '0;
                  ph_in    = 1'b0;
                  o_in     = '0;
                  d_in     = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!ph_ff) begin
               o_in     = o_ff + rob_pkg::O_W'(
                          $signed(prod_ff[rob_pkg::PROD_W-1:rob_pkg::FRAC]));
               ph_in    = 1'b1;
               state_in = ST_MUL;
            end else begin
               d_in  = d_ff + rob_pkg::D_W'(
                       $signed(prod_ff[rob_pkg::PROD_W-2:rob_pkg::FRAC]));
               ph_in = 1'b0;
               if (mi_ff == 2'd2) begin
                  state_in = ST_AXIS;
               end else begin
                  mi_in    = mi_ff + 2'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_AXIS: begin
            if (par) begin
               if (o_n < -e_n || o_n > e_n) begin
                  next_slot = 1'b1;
               end else begin
                  axis_end = 1'b1;
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               t1_in         = div_rsp.quo;
               div_req.start = 1'b1;
               div_req.num   = e_n - o_n;
               state_in      = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               if (tmin_n > tmax_n) begin
                  next_slot = 1'b1;
               end else begin
                  tmin_in  = tmin_n;
                  tmax_in  = tmax_n;
                  axis_end = 1'b1;
               end
            end
         end
         ST_FIN: begin
            if (tmin_ff < $signed({(rob_pkg::T_W - rob_pkg::DIST_W)'(0), best_ff})) begin
               best_in  = tmin_ff[rob_pkg::DIST_W-1:0];
               bslot_in = rob_pkg::SLOT_W'(scan_ff);
               found_in = 1'b1;
            end
            next_slot = 1'b1;
         end
         ST_PMUL: begin
            state_in = ST_PACC;
         end
         ST_PACC: begin
            if (psum > P_MAX) begin
               pt_in[mi_ff] = 32'sh7FFFFFFF;
            end else if (psum < P_MIN) begin
               pt_in[mi_ff] = 32'sh80000000;
            end else begin
               pt_in[mi_ff] = psum[31:0];
            end
            if (mi_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               mi_in    = mi_ff + 2'd1;
               state_in = ST_PMUL;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (axis_end) begin
         if (ax_ff == 2'd2) begin
            state_in = ST_FIN;
         end else begin
            ax_in    = ax_ff + 2'd1;
            mi_in    = '0;
            ph_in    = 1'b0;
            o_in     = '0;
            d_in     = '0;
            state_in = ST_MUL;
         end
      end
      if (next_slot) begin
         scan_in  = scan_ff + rob_pkg::SCAN_W'(1);
         base_in  = base_ff + rob_pkg::BASE_W'(rob_pkg::WORDS_PER_BOX);
         state_in = ST_SCAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         en_ff     <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         en_ff     <= en_in;
         rd_vld_ff <= rd_vld_in;
      end
      org_ff    <= org_in;
      dir_ff    <= dir_in;
      best_ff   <= best_in;
      found_ff  <= found_in;
      bslot_ff  <= bslot_in;
      scan_ff   <= scan_in;
      base_ff   <= base_in;
      ld_cnt_ff <= ld_cnt_in;
      rd_idx_ff <= rd_idx_in;
      diff_ff   <= diff_in;
      w_ff      <= w_in;
      ax_ff     <= ax_in;
      mi_ff     <= mi_in;
      ph_ff     <= ph_in;
      prod_ff   <= prod_c;
      o_ff      <= o_in;
      d_ff      <= d_in;
      tmin_ff   <= tmin_in;
      tmax_ff   <= tmax_in;
      t1_ff     <= t1_in;
      pt_ff     <= pt_in;
   end

   assign res_data.hit          = found_ff;
   assign res_data.hit_slot     = found_ff ? bslot_ff : '0;
   assign res_data.hit_distance = found_ff ? best_ff : '0;
   assign res_data.point_x      = found_ff ? pt_ff[0] : '0;
   assign res_data.point_y      = found_ff ? pt_ff[1] : '0;
   assign res_data.point_z      = found_ff ? pt_ff[2] : '0;
endmodule
`default_nettype wire

/* sv/ray_obb_nearest_hit_top.sv */
// A cast scans every slot and, on a hit, computes the hit point; each enabled slot loads
// its box words, then runs the slab test per axis, with the 42-step serial divider run
// twice per non-parallel axis.
// One cast is in flight at a time; its result goes to the output register, which holds it until taken.
// Reset clears slot enables and the output valid flag and sets the threshold to 1;
// box words are not cleared.
// ----------------------------------------------------------------------------
// Ray/OBB nearest hit: top level
// CSR threshold register, core and result output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_obb_nearest_hit_top_defines.svh"
module ray_obb_nearest_hit_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [rob_pkg::THR_W-1:0] csr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rob_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rob_pkg::rsp_type          rsp_data
);
   logic [rob_pkg::THR_W-1:0] thr_ff, thr_in;
   logic rsp_valid_ff, rsp_valid_in;
   rob_pkg::rsp_type rsp_data_ff, rsp_data_in, res_data;
   logic res_valid, res_ready;

   rob_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .thr       (thr_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   assign csr_ready = 1'b1;
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (csr_valid) begin
         thr_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= rob_pkg::THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ROB_ASSERT_NXT(a_cast_busy, clock, reset, req_valid && req_ready && req_data.operation == rob_pkg::OP_CAST, !req_ready)
   `ROB_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_data.hit, rsp_data.hit_slot == '0 && rsp_data.hit_distance == '0)
   `ROB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
endmodule
`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Ray/OBB nearest hit: testbench
// Loads oriented boxes, toggles slot enables and casts rays through the
// request channel under random stalls on both sides. Each cast result is
// compared field by field against an in-bench slab-test predictor. The
// parallel threshold is swept through its extremes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   localparam longint CYCLE_LIMIT = 4000000;
   localparam longint TSAT64      = longint'(1) << 40;
   localparam int     MAX_ON      = 6;
   localparam logic [1:0] OP_IGNORED = 2'd3;

   logic                        clock;
   logic                        reset;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [rob_pkg::THR_W-1:0]   csr_data;
   logic                        req_valid;
   logic                        req_ready;
   rob_pkg::req_type            req_data;
   logic                        rsp_valid;
   logic                        rsp_ready;
   rob_pkg::rsp_type            rsp_data;

   ray_obb_nearest_hit_top uut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   logic signed [31:0] box_mem [rob_pkg::BOX_SLOTS][rob_pkg::WORDS_PER_BOX];
   logic [rob_pkg::WORDS_PER_BOX-1:0] written [rob_pkg::BOX_SLOTS];
   logic               slot_on [rob_pkg::BOX_SLOTS];
   logic [rob_pkg::THR_W-1:0] threshold;
   rob_pkg::rsp_type   hit_queue [$];
   longint             cycles;
   int                 errors;
   int                 casts_checked;
   int                 hits_seen;
   int                 stall_left;
   bit                 quiet;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** ray_obb_nearest_hit_top: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (r < 12) begin
         stall_left <= (r < 2) ? $urandom_range(20, 90) : $urandom_range(0, 3);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rob_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hit_queue.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
         end else begin
            want = hit_queue.pop_front();
            casts_checked++;
            if (want.hit) hits_seen++;
            if (rsp_data.hit !== want.hit) begin
               $error("hit: expected %0d actual %0d", want.hit, rsp_data.hit);
               errors++;
            end
            if (rsp_data.hit_slot !== want.hit_slot) begin
               $error("hit_slot: expected %0d actual %0d", want.hit_slot, rsp_data.hit_slot);
               errors++;
            end
            if (rsp_data.hit_distance !== want.hit_distance) begin
               $error("hit_distance: expected %0h actual %0h",
                      want.hit_distance, rsp_data.hit_distance);
               errors++;
            end
            if (rsp_data.point_x !== want.point_x) begin
               $error("point_x: expected %0h actual %0h", want.point_x, rsp_data.point_x);
               errors++;
            end
            if (rsp_data.point_y !== want.point_y) begin
               $error("point_y: expected %0h actual %0h", want.point_y, rsp_data.point_y);
               errors++;
            end
            if (rsp_data.point_z !== want.point_z) begin
               $error("point_z: expected %0h actual %0h", want.point_z, rsp_data.point_z);
               errors++;
            end
         end
      end
   end

   function automatic longint slab_param(longint num, longint den);
      logic [63:0] n, d, q, r, res;
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = n / d;
      r = n % d;
      if (q >= (64'(TSAT64) >> 16)) res = 64'(TSAT64);
      else res = (q << 16) + ((r << 16) / d);
      if (res > 64'(TSAT64)) res = 64'(TSAT64);
      return ((num < 0) != (den < 0)) ? -longint'(res) : longint'(res);
   endfunction

   function automatic bit box_entry(int s, longint org[3], longint dir[3], output longint t);
      longint tmin, tmax, o, d, e, t1, t2, sw, ad;
      tmin = 0;
      tmax = TSAT64;
      t = 0;
      for (int a = 0; a < 3; a++) begin
         o = 0;
         d = 0;
         e = longint'(box_mem[s][rob_pkg::EXT_BASE + a]);
         for (int i = 0; i < 3; i++) begin
            o += ((org[i] - longint'(box_mem[s][i]))
                  * longint'(box_mem[s][3 + 3*a + i])) >>> 16;
            d += (dir[i] * longint'(box_mem[s][3 + 3*a + i])) >>> 16;
         end
         ad = (d < 0) ? -d : d;
         if (d == 0 || ad < longint'(threshold)) begin
            if (o < -e || o > e) return 1'b0;
         end else begin
            t1 = slab_param(-e - o, d);
            t2 = slab_param(e - o, d);
            if (t1 > t2) begin
               sw = t1;
               t1 = t2;
               t2 = sw;
            end
            if (t1 > tmin) tmin = t1;
            if (t2 < tmax) tmax = t2;
            if (tmin > tmax) return 1'b0;
         end
      end
      t = tmin;
      return 1'b1;
   endfunction

   function automatic rob_pkg::rsp_type nearest_hit(rob_pkg::req_type rq);
      rob_pkg::rsp_type res;
      longint org[3], dir[3], best, t, p;
      bit found;
      int best_slot;
      org = '{longint'(rq.origin_x), longint'(rq.origin_y), longint'(rq.origin_z)};
      dir = '{longint'(rq.dir_x), longint'(rq.dir_y), longint'(rq.dir_z)};
      best = longint'(rq.max_distance);
      found = 1'b0;
      best_slot = 0;
      res = '0;
      for (int s = 0; s < rob_pkg::BOX_SLOTS; s++) begin
         if (slot_on[s] && box_entry(s, org, dir, t) && t < best) begin
            best = t;
            best_slot = s;
            found = 1'b1;
         end
      end
      if (found) begin
         res.hit = 1'b1;
         res.hit_slot = best_slot[rob_pkg::SLOT_W-1:0];
         res.hit_distance = best[rob_pkg::DIST_W-1:0];
         for (int i = 0; i < 3; i++) begin
            p = org[i] + ((best * dir[i]) >>> 16);
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            if (i == 0) res.point_x = p[31:0];
            else if (i == 1) res.point_y = p[31:0];
            else res.point_z = p[31:0];
         end
      end
      return res;
   endfunction

   task automatic send_item(rob_pkg::req_type rq, bit no_gap = 0);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      gap = (quiet || no_gap || r < 45) ? 0 : (r < 95) ? $urandom_range(1, 3) :
            $urandom_range(10, 60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      case (rq.operation)
         rob_pkg::OP_WRITE: begin
            if (rq.word_index < rob_pkg::WORDS_PER_BOX) begin
               box_mem[rq.slot][rq.word_index] = rq.word_value;
               written[rq.slot][rq.word_index] = 1'b1;
            end
         end
         rob_pkg::OP_ENABLE: slot_on[rq.slot] = rq.word_value[0];
         rob_pkg::OP_CAST: hit_queue = {hit_queue, nearest_hit(rq)};
         default: ;
      endcase
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
   endtask

   task automatic drain_results();
      go_idle();
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_threshold(logic [rob_pkg::THR_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      threshold = value;
   endtask

   function automatic rob_pkg::req_type blank_req(logic [1:0] op);
      rob_pkg::req_type rq;
      rq = '0;
      rq.operation = op;
      rq.slot = rob_pkg::SLOT_W'($urandom);
      rq.word_index = rob_pkg::WIDX_W'($urandom);
      rq.word_value = $urandom;
      rq.origin_x = $urandom;
      rq.origin_y = $urandom;
      rq.origin_z = $urandom;
      rq.dir_x = $urandom;
      rq.dir_y = $urandom;
      rq.dir_z = $urandom;
      rq.max_distance = rob_pkg::DIST_W'($urandom);
      return rq;
   endfunction

   task automatic put_word(int s, int w, logic signed [31:0] v);
      rob_pkg::req_type rq;
      rq = blank_req(rob_pkg::OP_WRITE);
      rq.slot = s[rob_pkg::SLOT_W-1:0];
      rq.word_index = w[rob_pkg::WIDX_W-1:0];
      rq.word_value = v;
      send_item(rq);
   endtask

   task automatic set_slot(int s, bit on);
      rob_pkg::req_type rq;
      rq = blank_req(rob_pkg::OP_ENABLE);
      rq.slot = s[rob_pkg::SLOT_W-1:0];
      rq.word_value[0] = on;
      send_item(rq);
   endtask

   task automatic cast(int ox, int oy, int oz, int dx, int dy, int dz, int md);
      rob_pkg::req_type rq;
      rq = blank_req(rob_pkg::OP_CAST);
      rq.origin_x = ox;
      rq.origin_y = oy;
      rq.origin_z = oz;
      rq.dir_x = dx;
      rq.dir_y = dy;
      rq.dir_z = dz;
      rq.max_distance = md[rob_pkg::DIST_W-1:0];
      send_item(rq);
   endtask

   task automatic load_aligned_box(int s, int cx, int ext);
      for (int w = 0; w < rob_pkg::WORDS_PER_BOX; w++) begin
         if (w == 0) put_word(s, w, cx);
         else if (w < 3) put_word(s, w, 0);
         else if (w < rob_pkg::EXT_BASE)
            put_word(s, w, (w == 3 || w == 7 || w == 11) ? 65536 : 0);
         else put_word(s, w, ext);
      end
   endtask

   task automatic load_random_box(int s);
      int mode;
      int perm[3];
      logic signed [31:0] v;
      mode = $urandom_range(0, 9);
      perm = '{0, 1, 2};
      perm.shuffle();
      for (int w = 0; w < rob_pkg::WORDS_PER_BOX; w++) begin
         if (mode == 0) v = $urandom;
         else if (w < 3) v = $signed($urandom_range(0, 100 << 16)) - (50 << 16);
         else if (w < rob_pkg::EXT_BASE && mode < 5)
            v = (perm[(w - 3) / 3] == (w - 3) % 3) ?
                (($urandom_range(0, 1)) ? 65536 : -65536) : 0;
         else if (w < rob_pkg::EXT_BASE) v = $signed($urandom_range(0, 2 << 16)) - (1 << 16);
         else if (mode == 9) v = $signed($urandom_range(0, 20 << 16)) - (5 << 16);
         else v = $urandom_range(0, 40 << 16);
         put_word(s, w, v);
      end
   endtask

   function automatic int slots_on();
      int n;
      n = 0;
      foreach (slot_on[s]) n += slot_on[s];
      return n;
   endfunction

   task automatic random_cast();
      rob_pkg::req_type rq;
      rq = blank_req(rob_pkg::OP_CAST);
      if ($urandom_range(0, 9) != 0) begin
         rq.origin_x = $signed($urandom_range(0, 400 << 16)) - (200 << 16);
         rq.origin_y = $signed($urandom_range(0, 400 << 16)) - (200 << 16);
         rq.origin_z = $signed($urandom_range(0, 400 << 16)) - (200 << 16);
         rq.dir_x = ($urandom_range(0, 5) == 0) ? 0 :
                    $signed($urandom_range(0, 4 << 16)) - (2 << 16);
         rq.dir_y = ($urandom_range(0, 5) == 0) ? 0 :
                    $signed($urandom_range(0, 4 << 16)) - (2 << 16);
         rq.dir_z = ($urandom_range(0, 5) == 0) ? 0 :
                    $signed($urandom_range(0, 4 << 16)) - (2 << 16);
         if ($urandom_range(0, 3) != 0) rq.max_distance = $urandom_range(0, 1000 << 16);
      end
      send_item(rq);
   endtask

   task automatic test_directed();
      rob_pkg::req_type rq;
      load_aligned_box(0, 0, 10 << 16);
      set_slot(0, 1);
      cast(-100 << 16, 0, 0, 65536, 0, 0, 1000 << 16);
      cast(-100 << 16, 100 << 16, 0, 65536, 0, 0, 1000 << 16);
      cast(0, 20 << 16, 0, 65536, 0, 0, 1000 << 16);
      cast(0, 0, 0, 65536, 65536, 65536, 1000 << 16);
      cast(-100 << 16, 0, 0, 65536, 0, 0, 0);
      cast(-100 << 16, 0, 0, 65536, 0, 0, 32'h7fffffff);
      cast(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
           32'h7fffffff);
      load_aligned_box(1, 50 << 16, 5 << 16);
      load_aligned_box(2, 50 << 16, 5 << 16);
      set_slot(1, 1);
      set_slot(2, 1);
      set_slot(0, 0);
      cast(0, 0, 0, 65536, 0, 0, 1000 << 16);
      put_word(3, 15, 32'h12345678);
      load_aligned_box(3, -50 << 16, -(5 << 16));
      set_slot(3, 1);
      cast(0, 0, 0, -65536, 0, 0, 1000 << 16);
      rq = blank_req(OP_IGNORED);
      send_item(rq);
      cast(0, 0, 0, 65536, 0, 0, 1000 << 16);
      for (int s = 1; s < 4; s++) set_slot(s, 0);
      drain_results();
   endtask

   task automatic test_threshold_extremes();
      load_aligned_box(63, 0, 10 << 16);
      set_slot(63, 1);
      write_threshold('0);
      cast(-100 << 16, 0, 0, 65536, 1, 0, 1000 << 16);
      cast(-100 << 16, 20 << 16, 0, 65536, 0, 0, 1000 << 16);
      write_threshold('1);
      cast(-100 << 16, 0, 0, 65535, 0, 0, 1000 << 16);
      cast(-100 << 16, 0, 0, 65536, 0, 0, 1000 << 16);
      write_threshold(rob_pkg::THR_W'(1));
      set_slot(63, 0);
      drain_results();
   endtask

   task automatic test_random(int count);
      int s, r;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain_results();
         if (n == count / 4) quiet = 1'b1;
         if (n == count / 4 + 40) quiet = 1'b0;
         if (n % 150 == 149) write_threshold(rob_pkg::THR_W'($urandom));
         r = $urandom_range(0, 99);
         s = $urandom_range(0, rob_pkg::BOX_SLOTS - 1);
         if (r < 8) begin
            load_random_box(s);
         end else if (r < 18) begin
            if (&written[s] && slots_on() < MAX_ON) set_slot(s, 1);
            else set_slot(s, 0);
         end else if (r < 22) begin
            if (&written[s]) put_word(s, $urandom_range(0, 15), $urandom);
            else put_word(s, 15, $urandom);
         end else if (r < 24) begin
            send_item(blank_req(OP_IGNORED));
         end else begin
            random_cast();
         end
      end
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      cycles = 0;
      errors = 0;
      casts_checked = 0;
      hits_seen = 0;
      stall_left = 0;
      quiet = 1'b0;
      threshold = rob_pkg::THR_RESET;
      foreach (slot_on[s]) begin
         slot_on[s] = 1'b0;
         written[s] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_threshold_extremes();
      test_random(165);
      write_threshold(rob_pkg::THR_W'(1));
      repeat (100) @(posedge clock);
      $display("Checked %0d ray casts (%0d hits) over box loads, enables and threshold sweeps.",
               casts_checked, hits_seen);
      if (errors == 0 && hit_queue.size() == 0) begin
         $display("** ray_obb_nearest_hit_top: PASSED **");
      end else begin
         if (hit_queue.size() != 0) $error("%0d results never arrived", hit_queue.size());
         $display("** ray_obb_nearest_hit_top: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/rob_pkg.sv
sv/rob_div.sv
sv/rob_core.sv
sv/ray_obb_nearest_hit_top.sv
test/tb_top.sv
